@@ sv/mee_pkg.sv @@
// ----------------------------------------------------------------------------
// Microwire EEPROM master package
// Shared widths, command codes, item and result types, and the frame
// pattern helpers used by the front and back parts of the master.
// ----------------------------------------------------------------------------
package mee_pkg;

  localparam int ADDRESS_BITS = 6;
  localparam int DATA_BITS    = 8;
  localparam int KIND_W       = 3;
  localparam int ADDR_IN_W    = 6;
  localparam int HEAD_BITS    = 2 + ADDRESS_BITS;
  localparam int FRAME_BITS   = 1 + HEAD_BITS + DATA_BITS;
  localparam int SLOT_W       = $clog2(FRAME_BITS + 1);

  // Slot counts of a frame: short frames carry start, opcode and address only.
  localparam logic [SLOT_W-1:0] LEN_SHORT  = SLOT_W'(1 + HEAD_BITS);
  localparam logic [SLOT_W-1:0] LEN_LONG   = SLOT_W'(FRAME_BITS);
  localparam logic [SLOT_W-1:0] DATA_START = SLOT_W'(1 + HEAD_BITS);

  // Item kinds; the command codes double as the running operation.
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    OP_IDLE    = 3'd0,
    OP_READ    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FR_ENABLE  = 2'd0,
    FR_WRITE   = 2'd1,
    FR_DISABLE = 2'd2,
    FR_READ    = 2'd3
  } frame_e;

  localparam logic [1:0] WRITE_FRAMES = 2'd3;

  // Microwire opcodes.
  localparam logic [1:0] OPC_EXT   = 2'b00;
  localparam logic [1:0] OPC_WRITE = 2'b01;
  localparam logic [1:0] OPC_READ  = 2'b10;
  localparam logic [1:0] EWEN_ADDR = 2'b11;

  typedef struct packed {
    logic                    is_tick;
    op_e                     op;
    logic [ADDRESS_BITS-1:0] addr;
    logic [DATA_BITS-1:0]    data;
    logic                    dol;
  } item_t;

  typedef struct packed {
    logic                 chip_select;
    logic                 data_in_level;
    logic                 clock_pulse;
    logic                 busy_res;
    logic                 read_valid;
    logic [DATA_BITS-1:0] read_byte;
  } res_t;

  function automatic frame_e frame_kind(op_e op, logic [1:0] idx);
    frame_e fk;
    unique case (op)
      OP_READ:    fk = FR_READ;
      OP_ENABLE:  fk = FR_ENABLE;
      OP_DISABLE: fk = FR_DISABLE;
      OP_WRITE: begin
        if (idx == 2'd0) begin
          fk = FR_ENABLE;
        end else if (idx == 2'd1) begin
          fk = FR_WRITE;
        end else begin
          fk = FR_DISABLE;
        end
      end
      default:    fk = FR_DISABLE;
    endcase
    return fk;
  endfunction

  function automatic logic [SLOT_W-1:0] frame_len(frame_e fk);
    return ((fk == FR_WRITE) || (fk == FR_READ)) ? LEN_LONG : LEN_SHORT;
  endfunction

  // Frame bits left-aligned: the first slot's bit is the MSB.
  function automatic logic [FRAME_BITS-1:0] frame_bits(frame_e fk,
                                                        logic [ADDRESS_BITS-1:0] a,
                                                        logic [DATA_BITS-1:0] d);
    logic [FRAME_BITS-1:0] bits;
    unique case (fk)
      FR_ENABLE:  bits = {1'b1, OPC_EXT, EWEN_ADDR, {(ADDRESS_BITS-2){1'b0}},
                          {DATA_BITS{1'b0}}};
      FR_WRITE:   bits = {1'b1, OPC_WRITE, a, d};
      FR_READ:    bits = {1'b1, OPC_READ, a, {DATA_BITS{1'b0}}};
      default:    bits = {1'b1, {(FRAME_BITS-1){1'b0}}};
    endcase
    return bits;
  endfunction

endpackage

@@ sv/mee_front.sv @@
// ----------------------------------------------------------------------------
// Microwire EEPROM master front end
// Accepts items, decodes the kind, drops unknown kinds and holds the rest
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module mee_front import mee_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [ADDR_IN_W-1:0] address_i,
  input  logic [DATA_BITS-1:0] write_data_i,
  input  logic                 data_out_level_i,
  output item_t                item_o,
  output logic                 item_valid_o,
  input  logic                 item_pop_i
);

  localparam int DEPTH = 2;

  item_t       mem_q [DEPTH];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        keep;
  logic        wr_en;
  item_t       item_in;

  assign full   = (cnt_q == 2'(DEPTH));
  assign accept = push && !full;

  always_comb begin
    item_in         = '0;
    item_in.addr    = ADDRESS_BITS'(address_i);
    item_in.data    = write_data_i;
    item_in.dol     = data_out_level_i;
    keep            = 1'b1;
    unique case (kind_i)
      KIND_TICK: item_in.is_tick = 1'b1;
      OP_READ, OP_WRITE, OP_ENABLE, OP_DISABLE: item_in.op = op_e'(kind_i);
      default:   keep = 1'b0;
    endcase
  end

  assign wr_en = accept && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ item_pop_i;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign item_valid_o = (cnt_q != 2'd0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH)) else $error("front queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o) else $error("front queue popped while empty");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("front queue pointers disagree with the count");

endmodule

@@ sv/mee_back.sv @@
// ----------------------------------------------------------------------------
// Microwire EEPROM master sequencer
// Runs command sequences frame by frame, one bit slot per tick item, and
// places one result per tick into a two-entry result queue.
// ----------------------------------------------------------------------------
module mee_back import mee_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  item_t                item_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res_o
);

  localparam int DEPTH = 2;

  op_e                     op_q, op_d;
  logic [1:0]              idx_q, idx_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [FRAME_BITS-1:0]   shift_q, shift_d;
  logic [DATA_BITS-1:0]    hold_q, hold_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [DATA_BITS-1:0]    cap_q, cap_d;

  res_t        rmem_q [DEPTH];
  logic        rwr_q, rrd_q;
  logic [1:0]  rcnt_q;
  logic        res_full;
  logic        res_pop;
  logic        res_push;
  res_t        res_d;
  logic        take;
  frame_e      fk;
  logic [SLOT_W-1:0] len;
  logic [1:0]  next_idx;

  assign res_full   = (rcnt_q == 2'(DEPTH));
  assign take       = item_valid_i && !res_full;
  assign item_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_IDLE;
      idx_q  <= '0;
      slot_q <= '0;
    end else begin
      op_q   <= op_d;
      idx_q  <= idx_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    hold_q  <= hold_d;
    addr_q  <= addr_d;
    cap_q   <= cap_d;
  end

  always_comb begin
    op_d     = op_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    shift_d  = shift_q;
    hold_d   = hold_q;
    addr_d   = addr_q;
    cap_d    = cap_q;
    res_push = 1'b0;
    res_d    = '0;
    fk       = frame_kind(op_q, idx_q);
    len      = frame_len(fk);
    next_idx = idx_q + 2'd1;
    if (take) begin
      if (!item_i.is_tick) begin
        // A command only starts a sequence from idle; otherwise it is dropped.
        if (op_q == OP_IDLE) begin
          op_d    = item_i.op;
          idx_d   = '0;
          slot_d  = '0;
          addr_d  = item_i.addr;
          hold_d  = item_i.data;
          cap_d   = '0;
          shift_d = frame_bits(frame_kind(item_i.op, 2'd0), item_i.addr, item_i.data);
        end
      end else begin
        res_push = 1'b1;
        if (op_q != OP_IDLE) begin
          res_d.busy_res = 1'b1;
          if (slot_q < len) begin
            res_d.chip_select   = 1'b1;
            res_d.data_in_level = shift_q[FRAME_BITS-1];
            res_d.clock_pulse   = 1'b1;
            shift_d             = shift_q << 1;
            if ((fk == FR_READ) && (slot_q >= DATA_START)) begin
              cap_d = {cap_q[DATA_BITS-2:0], item_i.dol};
            end
            slot_d = slot_q + SLOT_W'(1);
          end else begin
            // Closing slot: chip select low, then the next frame or idle.
            if (fk == FR_READ) begin
              res_d.read_valid = 1'b1;
              res_d.read_byte  = cap_q;
            end
            if ((op_q == OP_WRITE) && (next_idx < WRITE_FRAMES)) begin
              idx_d   = next_idx;
              slot_d  = '0;
              shift_d = frame_bits(frame_kind(op_q, next_idx), addr_q, hold_q);
            end else begin
              op_d   = OP_IDLE;
              idx_d  = '0;
              slot_d = '0;
            end
          end
        end
      end
    end
  end

  // Result queue.
  assign res_pop = pop && !empty;
  assign empty   = (rcnt_q == 2'd0);
  assign res_o   = rmem_q[rrd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= '0;
    end else begin
      rwr_q  <= rwr_q ^ res_push;
      rrd_q  <= rrd_q ^ res_pop;
      rcnt_q <= rcnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rmem_q[rwr_q] <= res_d;
    end
  end

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_d.read_valid) |-> (res_d.busy_res && !res_d.chip_select))
    else $error("read result outside a running read");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q != OP_IDLE) |-> (slot_q <= LEN_LONG))
    else $error("slot counter ran past the frame");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_IDLE) |-> ((slot_q == '0) && (idx_q == 2'd0)))
    else $error("sequencer counters not cleared while idle");

  a_cs_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_d.chip_select) |-> (res_d.clock_pulse && res_d.busy_res))
    else $error("chip select without a clock pulse");

endmodule

@@ sv/microwire_eeprom_master.sv @@
// ----------------------------------------------------------------------------
// Microwire EEPROM master
// Drives a 64x8 serial EEPROM: command items start read, write, enable or
// disable sequences and each tick item reports one serial bit slot.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  input     push / full      kind_i, address_i, write_data_i, data_out_level_i
//  result    empty / pop      chip_select_o, data_in_level_o, clock_pulse_o,
//                             busy_res_o, read_valid_o, read_byte_o
//
// One item is accepted per cycle while full is low; a tick's result reaches the
// result ports through the front queue and then the result queue.
// Commands produce no result; unknown kinds are dropped at the front.
// Reset empties both queues and leaves the sequencer idle.
// full rises only after the result queue has filled while pop was low and two
// items wait in the front queue.
// ----------------------------------------------------------------------------
module microwire_eeprom_master import mee_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [ADDR_IN_W-1:0] address_i,
  input  logic [DATA_BITS-1:0] write_data_i,
  input  logic                 data_out_level_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 chip_select_o,
  output logic                 data_in_level_o,
  output logic                 clock_pulse_o,
  output logic                 busy_res_o,
  output logic                 read_valid_o,
  output logic [DATA_BITS-1:0] read_byte_o
);

  item_t item;
  logic  item_valid;
  logic  item_pop;
  res_t  res;

  mee_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .data_out_level_i (data_out_level_i),
    .item_o           (item),
    .item_valid_o     (item_valid),
    .item_pop_i       (item_pop)
  );

  mee_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign chip_select_o   = res.chip_select;
  assign data_in_level_o = res.data_in_level;
  assign clock_pulse_o   = res.clock_pulse;
  assign busy_res_o      = res.busy_res;
  assign read_valid_o    = res.read_valid;
  assign read_byte_o     = res.read_byte;

endmodule
